// ----- design/bdg_pkg.sv -----
// shared types and constants for the box downscale to gray block
package bdg_pkg;

  // fixed defaults of the top level parameters
  localparam int SRC_WIDTH_DEF  = 320;
  localparam int SRC_HEIGHT_DEF = 200;
  localparam int MAX_TILE_DEF   = 16;

  // accumulator store and output limits
  localparam int SUM_W      = 16;
  localparam int SUM_DEPTH  = 320;
  localparam int ROW_LIMIT  = 200;

  // configuration register widths
  localparam int BLK_REG_W  = 5;
  localparam int COLS_REG_W = 9;
  localparam int ROWS_REG_W = 8;
  localparam int OFFS_REG_W = 10;
  localparam int CFG_W      = 10;
  localparam int CFG_IDX_W  = 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_W       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_H       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_COLS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_ROWS      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_OFFSET = 3'd4;

  // register reset values
  localparam logic [BLK_REG_W-1:0]  BLOCK_W_RST  = 5'd1;
  localparam logic [BLK_REG_W-1:0]  BLOCK_H_RST  = 5'd1;
  localparam logic [COLS_REG_W-1:0] OUT_COLS_RST = 9'd320;
  localparam logic [ROWS_REG_W-1:0] OUT_ROWS_RST = 8'd200;
  localparam logic [OFFS_REG_W-1:0] OFFSET_RST   = 10'd0;

  // pixel and result widths
  localparam int COLOR_W   = 8;
  localparam int GRAY_W    = 8;
  localparam int OUT_COL_W = 11;
  localparam int OUT_ROW_W = 8;
  localparam int S_DATA_W  = 24;
  localparam int M_DATA_W  = 32;

  // luma weights, divide by 100 done as reciprocal multiply, reciprocal rounded up
  localparam int LUMA_R      = 30;
  localparam int LUMA_G      = 59;
  localparam int LUMA_B      = 11;
  localparam int LUMA_DIV    = 100;
  localparam int WSUM_W      = 15;
  localparam int RECIP_SHIFT = 19;
  localparam int RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] LUMA_RECIP =
    RECIP_W'((2 ** RECIP_SHIFT + LUMA_DIV - 1) / LUMA_DIV);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- design/bdg_ram.sv -----
// generic single write port ram with registered read
module bdg_ram #(
  parameter int WIDTH = bdg_pkg::SUM_W,
  parameter int DEPTH = bdg_pkg::SUM_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/bdg_div.sv -----
// restoring divider, one quotient bit per cycle
module bdg_div #(
  parameter int DIVISOR_W = 9
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [bdg_pkg::SUM_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]     divisor,
  output logic [bdg_pkg::SUM_W-1:0] quotient,
  output bdg_pkg::div_stat_t       stat
);

  localparam int CNT_W = $clog2(bdg_pkg::SUM_W + 1);

  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W-1:0] rem;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic                 done;
  logic [DIVISOR_W:0]   trial;
  logic                 qbit;
  logic [DIVISOR_W:0]   trial_diff;

  always_comb begin
    trial      = {rem, quotient[bdg_pkg::SUM_W-1]};
    qbit       = (trial >= {1'b0, dvs});
    trial_diff = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(bdg_pkg::SUM_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // payload path, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      dvs      <= divisor;
      rem      <= '0;
      quotient <= dividend;
    end else if (busy) begin
      // remainder stays below the divisor, so the low bits suffice
      rem      <= qbit ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quotient <= {quotient[bdg_pkg::SUM_W-2:0], qbit};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ----- design/box_downscale_to_gray.sv -----
// top level of the box downscale to gray block
// Box downscale to gray.
// Source pixels come in on the s_ channel in raster order, one per transaction,
// with s_tuser set on the first pixel of a frame. Each pixel is turned into a
// gray level and added into a per-column tile accumulator held in a ram.
// When a tile's last pixel arrives, one result leaves on the m_ channel with
// the tile average, its output column (plus column offset) and output row;
// m_tlast marks the last tile of the frame.
// Items are handled one at a time: a pixel that completes no tile is accepted
// with a ram read, then modified and written back; a pixel that completes a
// tile also waits for the 16-step bit-serial divider that forms the average.
// The output register lets the next pixel be accepted while a result waits;
// if a new result is ready while m_tready stays low, the block holds it and
// accepts nothing until the output register is taken.
// Configuration must be written through cfg_we/cfg_index/cfg_data only while
// idle; the block itself does not enforce this. Reset (rst, synchronous)
// restores register defaults, clears the position counters; the accumulator
// ram is not cleared: every band's first row overwrites it before any read.
module box_downscale_to_gray #(
  parameter int SRC_WIDTH  = bdg_pkg::SRC_WIDTH_DEF,
  parameter int SRC_HEIGHT = bdg_pkg::SRC_HEIGHT_DEF,
  parameter int MAX_TILE   = bdg_pkg::MAX_TILE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [bdg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdg_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [bdg_pkg::S_DATA_W-1:0]   s_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic                           s_tuser,   // frame_start
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [bdg_pkg::M_DATA_W-1:0]   m_tdata,   // gray[7:0], out_col[18:8], out_row[26:19]
  output logic                           m_tlast    // frame_end
);

  localparam int SCW   = $clog2(SRC_WIDTH);
  localparam int SRW   = $clog2(SRC_HEIGHT);
  localparam int TCW   = (MAX_TILE > 1) ? $clog2(MAX_TILE) : 1;
  localparam int BKW   = $clog2(MAX_TILE + 1);
  localparam int EXW   = (BKW > bdg_pkg::BLK_REG_W) ? BKW : bdg_pkg::BLK_REG_W;
  localparam int CMPW  = BKW + 1;
  localparam int AREAW = $clog2(MAX_TILE * MAX_TILE + 1);
  localparam int ADRW  = $clog2(bdg_pkg::SUM_DEPTH);
  localparam int TCOLW = $clog2(bdg_pkg::SUM_DEPTH + 1);
  localparam int BROW  = bdg_pkg::OUT_ROW_W;
  localparam int PRODW = bdg_pkg::WSUM_W + bdg_pkg::RECIP_W;

  // configuration registers
  logic [bdg_pkg::BLK_REG_W-1:0]  block_w;
  logic [bdg_pkg::BLK_REG_W-1:0]  block_h;
  logic [bdg_pkg::COLS_REG_W-1:0] out_cols;
  logic [bdg_pkg::ROWS_REG_W-1:0] out_rows;
  logic [bdg_pkg::OFFS_REG_W-1:0] column_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_w       <= bdg_pkg::BLOCK_W_RST;
      block_h       <= bdg_pkg::BLOCK_H_RST;
      out_cols      <= bdg_pkg::OUT_COLS_RST;
      out_rows      <= bdg_pkg::OUT_ROWS_RST;
      column_offset <= bdg_pkg::OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bdg_pkg::REG_BLOCK_W:       block_w       <= cfg_data[bdg_pkg::BLK_REG_W-1:0];
        bdg_pkg::REG_BLOCK_H:       block_h       <= cfg_data[bdg_pkg::BLK_REG_W-1:0];
        bdg_pkg::REG_OUT_COLS:      out_cols      <= cfg_data[bdg_pkg::COLS_REG_W-1:0];
        bdg_pkg::REG_OUT_ROWS:      out_rows      <= cfg_data[bdg_pkg::ROWS_REG_W-1:0];
        bdg_pkg::REG_COLUMN_OFFSET: column_offset <= cfg_data[bdg_pkg::OFFS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // effective block and output sizes
  logic [EXW-1:0]                 bw_ext;
  logic [EXW-1:0]                 bh_ext;
  logic [BKW-1:0]                 bw;
  logic [BKW-1:0]                 bh;
  logic [2*BKW-1:0]               area_full;
  logic [TCOLW-1:0]               oc;
  logic [BROW-1:0]                orow;

  always_comb begin
    bw_ext = EXW'(block_w);
    bh_ext = EXW'(block_h);
    if (bw_ext == '0) begin
      bw = BKW'(1);
    end else if (bw_ext > EXW'(MAX_TILE)) begin
      bw = BKW'(MAX_TILE);
    end else begin
      bw = bw_ext[BKW-1:0];
    end
    if (bh_ext == '0) begin
      bh = BKW'(1);
    end else if (bh_ext > EXW'(MAX_TILE)) begin
      bh = BKW'(MAX_TILE);
    end else begin
      bh = bh_ext[BKW-1:0];
    end
    area_full = (2*BKW)'(bw) * (2*BKW)'(bh);
    oc   = (out_cols > bdg_pkg::COLS_REG_W'(bdg_pkg::SUM_DEPTH)) ?
           TCOLW'(bdg_pkg::SUM_DEPTH) : TCOLW'(out_cols);
    orow = (out_rows > bdg_pkg::ROWS_REG_W'(bdg_pkg::ROW_LIMIT)) ?
           BROW'(bdg_pkg::ROW_LIMIT) : BROW'(out_rows);
  end

  // position counters
  logic [SCW-1:0]   src_col,     src_col_next;
  logic [SRW-1:0]   src_row,     src_row_next;
  logic [TCW-1:0]   col_in_tile, col_in_tile_next;
  logic [TCW-1:0]   row_in_band, row_in_band_next;
  logic [TCOLW-1:0] tile_col,    tile_col_next;
  logic [BROW-1:0]  band_row,    band_row_next;

  // values seen by this pixel, after a frame start clear
  logic [SCW-1:0]   sc_e;
  logic [SRW-1:0]   sr_e;
  logic [TCW-1:0]   ct_e;
  logic [TCW-1:0]   rb_e;
  logic [TCOLW-1:0] tc_e;
  logic [BROW-1:0]  br_e;
  logic             col_end;
  logic             row_end;
  logic             active;
  logic             emit;
  logic             last_tile;
  logic [bdg_pkg::WSUM_W-1:0] wsum_in;

  logic accept;
  assign accept = s_tvalid && s_tready;

  always_comb begin
    sc_e = s_tuser ? '0 : src_col;
    sr_e = s_tuser ? '0 : src_row;
    ct_e = s_tuser ? '0 : col_in_tile;
    rb_e = s_tuser ? '0 : row_in_band;
    tc_e = s_tuser ? '0 : tile_col;
    br_e = s_tuser ? '0 : band_row;

    col_end   = (CMPW'(ct_e) + CMPW'(1)) >= CMPW'(bw);
    row_end   = (CMPW'(rb_e) + CMPW'(1)) >= CMPW'(bh);
    active    = (tc_e < oc) && (br_e < orow);
    emit      = active && col_end && row_end;
    last_tile = ((tc_e + TCOLW'(1)) == oc) && ((br_e + BROW'(1)) == orow);

    wsum_in = bdg_pkg::WSUM_W'(s_tdata[7:0])   * bdg_pkg::WSUM_W'(bdg_pkg::LUMA_R)
            + bdg_pkg::WSUM_W'(s_tdata[15:8])  * bdg_pkg::WSUM_W'(bdg_pkg::LUMA_G)
            + bdg_pkg::WSUM_W'(s_tdata[23:16]) * bdg_pkg::WSUM_W'(bdg_pkg::LUMA_B);

    // horizontal advance, tile column saturates at the output width
    if (col_end) begin
      col_in_tile_next = '0;
      tile_col_next    = (tc_e < oc) ? tc_e + TCOLW'(1) : tc_e;
    end else begin
      col_in_tile_next = ct_e + TCW'(1);
      tile_col_next    = tc_e;
    end
    src_col_next     = sc_e + SCW'(1);
    src_row_next     = sr_e;
    row_in_band_next = rb_e;
    band_row_next    = br_e;

    // end of source row
    if (sc_e == SCW'(SRC_WIDTH - 1)) begin
      src_col_next     = '0;
      col_in_tile_next = '0;
      tile_col_next    = '0;
      if (row_end) begin
        row_in_band_next = '0;
        band_row_next    = (br_e < orow) ? br_e + BROW'(1) : br_e;
      end else begin
        row_in_band_next = rb_e + TCW'(1);
      end
      src_row_next = sr_e + SRW'(1);
      // end of frame wraps everything to the origin
      if (sr_e == SRW'(SRC_HEIGHT - 1)) begin
        src_row_next     = '0;
        row_in_band_next = '0;
        band_row_next    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col     <= '0;
      src_row     <= '0;
      col_in_tile <= '0;
      row_in_band <= '0;
      tile_col    <= '0;
      band_row    <= '0;
    end else if (accept) begin
      src_col     <= src_col_next;
      src_row     <= src_row_next;
      col_in_tile <= col_in_tile_next;
      row_in_band <= row_in_band_next;
      tile_col    <= tile_col_next;
      band_row    <= band_row_next;
    end
  end

  // item held across the read-modify-write
  logic [ADRW-1:0]               it_addr;
  logic                          it_first;
  logic                          it_active;
  logic                          it_emit;
  logic                          it_last;
  logic [bdg_pkg::OUT_COL_W-1:0] it_col;
  logic [BROW-1:0]               it_row;
  logic [AREAW-1:0]              it_area;
  logic [bdg_pkg::WSUM_W-1:0]    wsum;

  always_ff @(posedge clk) begin
    if (accept) begin
      it_addr   <= tc_e[ADRW-1:0];
      it_first  <= (rb_e == '0) && (ct_e == '0);
      it_active <= active;
      it_emit   <= emit;
      it_last   <= last_tile;
      it_col    <= bdg_pkg::OUT_COL_W'(tc_e) + bdg_pkg::OUT_COL_W'(column_offset);
      it_row    <= br_e;
      it_area   <= area_full[AREAW-1:0];
      wsum      <= wsum_in;
    end
  end

  // control
  bdg_pkg::state_t state, state_next;
  bdg_pkg::div_stat_t div_stat;

  logic                          ram_we;
  logic [bdg_pkg::SUM_W-1:0]     ram_rdata;
  logic [bdg_pkg::SUM_W-1:0]     sum;
  logic [PRODW-1:0]              luma_prod;
  logic [bdg_pkg::GRAY_W-1:0]    lum;
  logic [bdg_pkg::SUM_W-1:0]     quotient;
  logic                          div_start;
  logic                          out_free;
  logic                          out_load;

  always_comb begin
    luma_prod = PRODW'(wsum) * PRODW'(bdg_pkg::LUMA_RECIP);
    lum       = luma_prod[bdg_pkg::RECIP_SHIFT +: bdg_pkg::GRAY_W];
    sum       = it_first ? bdg_pkg::SUM_W'(lum) : ram_rdata + bdg_pkg::SUM_W'(lum);
  end

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ram_we     = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state)
      bdg_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = bdg_pkg::ST_UPDATE;
        end
      end
      bdg_pkg::ST_UPDATE: begin
        ram_we = it_active;
        if (it_emit) begin
          div_start  = 1'b1;
          state_next = bdg_pkg::ST_DIV;
        end else begin
          state_next = bdg_pkg::ST_IDLE;
        end
      end
      bdg_pkg::ST_DIV: begin
        if (div_stat.done) begin
          if (out_free) begin
            out_load   = 1'b1;
            state_next = bdg_pkg::ST_IDLE;
          end else begin
            state_next = bdg_pkg::ST_HOLD;
          end
        end
      end
      bdg_pkg::ST_HOLD: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = bdg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bdg_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdg_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  bdg_ram #(
    .WIDTH (bdg_pkg::SUM_W),
    .DEPTH (bdg_pkg::SUM_DEPTH)
  ) u_sums (
    .clk   (clk),
    .we    (ram_we),
    .waddr (it_addr),
    .wdata (sum),
    .raddr (tc_e[ADRW-1:0]),
    .rdata (ram_rdata)
  );

  bdg_div #(
    .DIVISOR_W (AREAW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (it_area),
    .quotient (quotient),
    .stat     (div_stat)
  );

  // output register
  logic [bdg_pkg::GRAY_W-1:0]    out_gray;
  logic [bdg_pkg::OUT_COL_W-1:0] out_col;
  logic [BROW-1:0]               out_row;
  logic                          frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_gray  <= quotient[bdg_pkg::GRAY_W-1:0];
      out_col   <= it_col;
      out_row   <= it_row;
      frame_end <= it_last;
    end
  end

  assign m_tdata = {
    {(bdg_pkg::M_DATA_W - bdg_pkg::GRAY_W - bdg_pkg::OUT_COL_W - BROW){1'b0}},
    out_row, out_col, out_gray
  };
  assign m_tlast = frame_end;

  // divider only runs for a tile that is being closed
  assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> (state == bdg_pkg::ST_DIV))
    else $error("divider busy outside the divide state");

  // an accepted pixel always goes through the write-back cycle next
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == bdg_pkg::ST_UPDATE))
    else $error("accepted pixel skipped the accumulator update");

  // a new result only appears after a finished division
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == bdg_pkg::ST_DIV || $past(state) == bdg_pkg::ST_HOLD))
    else $error("result presented without a division");

  // no new pixel is taken while a finished average is still held back
  assert property (@(posedge clk) disable iff (rst)
    (state == bdg_pkg::ST_HOLD) |-> (!s_tready && m_tvalid))
    else $error("hold state without a pending result");

endmodule

// ----- tb/sv/tb_box_downscale_to_gray.sv -----
// self-checking testbench for box_downscale_to_gray, pixel stream in and tile averages out
module tb_box_downscale_to_gray;

  localparam int ROW_PIXELS     = 320;
  localparam int FRAME_ROWS     = 200;
  localparam int TILE_MAX       = 16;
  localparam int COL_LIMIT      = 320;
  localparam int BAND_LIMIT     = 200;
  localparam int W_RED          = 30;
  localparam int W_GREEN        = 59;
  localparam int W_BLUE         = 11;
  localparam int W_SCALE        = 100;
  localparam int RESULT_LATENCY = 19;
  localparam int SETTLE_CYCLES  = 25;
  localparam int STALL_LIMIT    = 2000;
  localparam int LONG_HOLD      = 400;
  localparam int RANDOM_PIXELS  = 680;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       frame_start;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  gray;
    logic [10:0] out_col;
    logic [7:0]  out_row;
    logic        frame_end;
  } tile_res_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_we;
  logic [bdg_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bdg_pkg::CFG_W-1:0]     cfg_data;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [bdg_pkg::S_DATA_W-1:0]  s_tdata;   // red[7:0], green[15:8], blue[23:16]
  logic                          s_tuser;   // frame_start
  logic                          m_tvalid;
  logic                          m_tready;
  logic [bdg_pkg::M_DATA_W-1:0]  m_tdata;   // gray[7:0], out_col[18:8], out_row[26:19]
  logic                          m_tlast;   // frame_end

  box_downscale_to_gray #(
    .SRC_WIDTH (ROW_PIXELS),
    .SRC_HEIGHT(FRAME_ROWS),
    .MAX_TILE  (TILE_MAX)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow registers and position of the predictor
  logic [4:0]  reg_block_w;
  logic [4:0]  reg_block_h;
  logic [8:0]  reg_out_cols;
  logic [7:0]  reg_out_rows;
  logic [9:0]  reg_col_offset;
  logic [15:0] tile_acc [COL_LIMIT];
  int unsigned pos_col, pos_row, sub_col, sub_row, tile_x, band_y;

  tile_res_t pending_tiles [$];
  int        mismatches      = 0;

  // stimulus controls
  bit tx_gaps     = 1'b0;
  bit rx_stalls   = 1'b0;
  int burst_left  = 0;
  int rx_hold_len = 0;

  function automatic int unsigned clamp_tile(input logic [4:0] v);
    if (v == 0) begin
      return 1;
    end
    return (v > TILE_MAX) ? TILE_MAX : v;
  endfunction

  function automatic void clear_position();
    pos_col = 0;
    pos_row = 0;
    sub_col = 0;
    sub_row = 0;
    tile_x  = 0;
    band_y  = 0;
  endfunction

  function automatic void reset_model();
    reg_block_w    = 5'd1;
    reg_block_h    = 5'd1;
    reg_out_cols   = 9'd320;
    reg_out_rows   = 8'd200;
    reg_col_offset = 10'd0;
    clear_position();
  endfunction

  // gray conversion, tile accumulation and position advance for one accepted pixel
  function automatic void accumulate_pixel(input pixel_t px);
    int unsigned bw, bh, oc, orows, lum, sum;
    tile_res_t   res;
    bw    = clamp_tile(reg_block_w);
    bh    = clamp_tile(reg_block_h);
    oc    = (reg_out_cols > COL_LIMIT) ? COL_LIMIT : reg_out_cols;
    orows = (reg_out_rows > BAND_LIMIT) ? BAND_LIMIT : reg_out_rows;
    lum   = (px.red * W_RED + px.green * W_GREEN + px.blue * W_BLUE) / W_SCALE;
    if (px.frame_start) begin
      clear_position();
    end
    if (tile_x < oc && band_y < orows) begin
      if (sub_row == 0 && sub_col == 0) begin
        sum = lum;
      end else begin
        sum = (tile_acc[tile_x] + lum) & 16'hFFFF;
      end
      tile_acc[tile_x] = sum[15:0];
      if (sub_col + 1 >= bw && sub_row + 1 >= bh) begin
        res.gray      = 8'(sum / (bw * bh));
        res.out_col   = 11'(tile_x + reg_col_offset);
        res.out_row   = 8'(band_y);
        res.frame_end = (tile_x + 1 == oc) && (band_y + 1 == orows);
        pending_tiles.push_back(res);
      end
    end
    if (sub_col + 1 >= bw) begin
      sub_col = 0;
      if (tile_x < oc) tile_x++;
    end else begin
      sub_col++;
    end
    pos_col++;
    if (pos_col >= ROW_PIXELS) begin
      pos_col = 0;
      sub_col = 0;
      tile_x  = 0;
      if (sub_row + 1 >= bh) begin
        sub_row = 0;
        if (band_y < orows) band_y++;
      end else begin
        sub_row++;
      end
      pos_row++;
      if (pos_row >= FRAME_ROWS) begin
        clear_position();
      end
    end
  endfunction

  function automatic void flag_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch at %0t: %s", $realtime, msg);
    end
  endfunction

  function automatic void check_tile();
    tile_res_t want;
    if (pending_tiles.size() == 0) begin
      flag_error($sformatf("result with none expected, tdata %h tlast %b", m_tdata, m_tlast));
    end else begin
      want = pending_tiles.pop_front();
      if (m_tdata[7:0] !== want.gray) begin
        flag_error($sformatf("gray expected %0d got %0d", want.gray, m_tdata[7:0]));
      end
      if (m_tdata[18:8] !== want.out_col) begin
        flag_error($sformatf("out_col expected %0d got %0d", want.out_col, m_tdata[18:8]));
      end
      if (m_tdata[26:19] !== want.out_row) begin
        flag_error($sformatf("out_row expected %0d got %0d", want.out_row, m_tdata[26:19]));
      end
      if (m_tlast !== want.frame_end) begin
        flag_error($sformatf("frame_end expected %b got %b", want.frame_end, m_tlast));
      end
    end
  endfunction

  // values are stable between the falling edge and the next rising edge
  always @(negedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      check_tile();
    end
  end

  // receiver: always ready, a random ready pattern, or a long hold-off on request
  initial begin : rx_side
    int run;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_len > 0) begin
        run = rx_hold_len;
        rx_hold_len = 0;
        m_tready <= 1'b0;
        while (run > 0) begin
          @(posedge clk);
          run--;
        end
      end else if (!rx_stalls) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= ($urandom_range(0, 2) != 0);
        run = $urandom_range(1, 6);
        repeat (run) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    while (stuck < STALL_LIMIT) begin
      @(negedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || rst) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  task automatic send_pixel(input pixel_t px);
    if (tx_gaps) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
    s_tdata  <= {px.blue, px.green, px.red};
    s_tuser  <= px.frame_start;
    s_tvalid <= 1'b1;
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    accumulate_pixel(px);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_tiles.size() != 0);
  endtask

  task automatic write_reg(input logic [bdg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [bdg_pkg::CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      bdg_pkg::REG_BLOCK_W:       reg_block_w    = value[4:0];
      bdg_pkg::REG_BLOCK_H:       reg_block_h    = value[4:0];
      bdg_pkg::REG_OUT_COLS:      reg_out_cols   = value[8:0];
      bdg_pkg::REG_OUT_ROWS:      reg_out_rows   = value[7:0];
      bdg_pkg::REG_COLUMN_OFFSET: reg_col_offset = value[9:0];
      default: ;
    endcase
  endtask

  // the block may still be busy on a pixel that makes no result
  task automatic set_config(input int bw, input int bh, input int cols, input int rows,
                            input int offs);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(bdg_pkg::REG_BLOCK_W, bdg_pkg::CFG_W'(bw));
    write_reg(bdg_pkg::REG_BLOCK_H, bdg_pkg::CFG_W'(bh));
    write_reg(bdg_pkg::REG_OUT_COLS, bdg_pkg::CFG_W'(cols));
    write_reg(bdg_pkg::REG_OUT_ROWS, bdg_pkg::CFG_W'(rows));
    write_reg(bdg_pkg::REG_COLUMN_OFFSET, bdg_pkg::CFG_W'(offs));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [7:0] random_level();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_run(input int count, input bit lead_start, input bit stray);
    int     stray_at;
    pixel_t px;
    stray_at = (stray && count > 1) ? $urandom_range(1, count - 1) : -1;
    for (int i = 0; i < count; i++) begin
      px.red         = random_level();
      px.green       = random_level();
      px.blue        = random_level();
      px.frame_start = (i == 0 && lead_start) || (i == stray_at);
      send_pixel(px);
    end
  endtask

  task automatic test_colour_extremes();
    pixel_t px;
    tx_gaps   = 1'b0;
    rx_stalls = 1'b0;
    set_config(1, 1, 320, 200, 1023);
    for (int i = 0; i < 8; i++) begin
      px.red         = i[0] ? 8'hFF : 8'h00;
      px.green       = i[1] ? 8'hFF : 8'h00;
      px.blue        = i[2] ? 8'hFF : 8'h00;
      px.frame_start = (i == 0);
      send_pixel(px);
    end
    send_run(4, 1'b0, 1'b0);
  endtask

  task automatic test_block_limits();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    // zero block size acts as one, zero output columns gives nothing
    set_config(0, 0, 0, 1, 0);
    send_run(4, 1'b1, 1'b0);
    // oversized block width acts as the largest tile
    set_config(31, 0, 2, 1, 7);
    send_run(32, 1'b1, 1'b0);
  endtask

  task automatic test_frame_edges();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    // output sizes beyond the frame clamp, last partial tile of a row never completes
    set_config(3, 2, 511, 255, $urandom_range(0, 1023));
    send_run(2 * ROW_PIXELS, 1'b1, 1'b0);
  endtask

  task automatic test_column_saturation();
    // tile column stops at the output width, later pixels of the row are dropped
    set_config(2, 1, 3, 1, 0);
    send_run(8, 1'b1, 1'b0);
  endtask

  task automatic test_backpressure();
    tx_gaps   = 1'b0;
    rx_stalls = 1'b1;
    set_config(1, 1, 320, 200, $urandom_range(0, 1023));
    rx_hold_len = LONG_HOLD;
    send_run(80, 1'b1, 1'b0);
    wait_drained();
    send_run(40, 1'b0, 1'b0);
  endtask

  task automatic test_random();
    int sent, bw, bh, cols, rows, span;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      tx_gaps   = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 11))
          0:       bw = 0;
          1:       bw = $urandom_range(17, 31);
          2, 3:    bw = $urandom_range(1, TILE_MAX);
          default: bw = $urandom_range(1, 4);
        endcase
        case ($urandom_range(0, 11))
          0:       bh = 0;
          1:       bh = $urandom_range(17, 31);
          2:       bh = $urandom_range(5, TILE_MAX);
          default: bh = $urandom_range(1, 2);
        endcase
        case ($urandom_range(0, 11))
          0:       cols = 0;
          1:       cols = $urandom_range(321, 511);
          2:       cols = 320;
          default: cols = $urandom_range(1, 40);
        endcase
        case ($urandom_range(0, 11))
          0:       rows = 0;
          1:       rows = $urandom_range(201, 255);
          default: rows = $urandom_range(1, 3);
        endcase
        set_config(bw, bh, cols, rows, $urandom_range(0, 1023));
      end
      // mostly short runs, now and then one that crosses into the next row
      span = ($urandom_range(0, 7) == 0) ? ROW_PIXELS + $urandom_range(1, 64) :
                                           $urandom_range(8, 120);
      if (span > RANDOM_PIXELS - sent) begin
        span = RANDOM_PIXELS - sent;
      end
      // mostly clean runs from a frame start, some with a stray restart inside
      send_run(span, 1'b1, $urandom_range(0, 5) == 0);
      sent += span;
    end
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= 1'b0;
    reset_model();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_colour_extremes();
    test_block_limits();
    test_frame_edges();
    test_column_saturation();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (RESULT_LATENCY + SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_tiles.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/bdg_pkg.sv
design/bdg_ram.sv
design/bdg_div.sv
design/box_downscale_to_gray.sv
tb/sv/tb_box_downscale_to_gray.sv
